### design/lcdts_pkg.sv
`timescale 1ns / 1ps

package lcdts_pkg;

    // Operation codes
    localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
    localparam logic [2:0] OP_SET_POS    = 3'd1;
    localparam logic [2:0] OP_CLEAR      = 3'd2;
    localparam logic [2:0] OP_CURSOR_ON  = 3'd3;
    localparam logic [2:0] OP_CURSOR_OFF = 3'd4;
    localparam logic [2:0] OP_INIT       = 3'd5;

    // Special characters
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Delay classes
    localparam logic [1:0] WAIT_NONE  = 2'd0;
    localparam logic [1:0] WAIT_SHORT = 2'd1;
    localparam logic [1:0] WAIT_LONG  = 2'd2;

    // Register select
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // LCD commands and address limits
    localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_CURSOR_ON   = 8'h0e;
    localparam logic [7:0] CMD_CURSOR_OFF  = 8'h0c;
    localparam logic [6:0] ADDR_LINE1_END  = 7'h28;
    localparam logic [6:0] ADDR_LINE2      = 7'h40;
    localparam logic [6:0] ADDR_LINE2_END  = 7'h68;

    // Last step of each run kind
    localparam logic [3:0] LAST_STEP_BYTE      = 4'd1;
    localparam logic [3:0] LAST_STEP_BACKSPACE = 4'd5;
    localparam logic [3:0] LAST_STEP_INIT      = 4'd15;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] char_code;
        logic [1:0] row;
        logic [5:0] col;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0] nibble;
        logic       reg_select;
        logic [1:0] pre_wait;
        logic [1:0] post_wait;
        logic       last;
    } lcd_item_t;

    typedef enum logic [1:0] {
        RUN_BYTE,
        RUN_BACKSPACE,
        RUN_INIT
    } run_kind_t;

    // One queued run: the back end expands it into strobes
    typedef struct packed {
        run_kind_t  kind;
        logic [7:0] data;
        logic       reg_select;
        logic [1:0] post_wait;
    } run_t;

    typedef struct packed {
        logic [3:0] nibble;
        logic [1:0] pre_wait;
        logic [1:0] post_wait;
    } init_step_t;

    // Power-on sequence: four single nibbles, then six command bytes
    function automatic init_step_t init_strobe(input logic [3:0] step);
        init_step_t s;
        s = '{nibble: 4'h0, pre_wait: WAIT_NONE, post_wait: WAIT_NONE};
        unique case (step)
            4'd0:    s = '{4'h3, WAIT_LONG, WAIT_LONG};
            4'd1:    s = '{4'h3, WAIT_NONE, WAIT_LONG};
            4'd2:    s = '{4'h3, WAIT_NONE, WAIT_NONE};
            4'd3:    s = '{4'h2, WAIT_NONE, WAIT_NONE};
            4'd4:    s = '{4'h2, WAIT_NONE, WAIT_NONE};
            4'd5:    s = '{4'h8, WAIT_NONE, WAIT_SHORT};
            4'd6:    s = '{4'h0, WAIT_NONE, WAIT_NONE};
            4'd7:    s = '{4'h8, WAIT_NONE, WAIT_SHORT};
            4'd8:    s = '{4'h0, WAIT_NONE, WAIT_NONE};
            4'd9:    s = '{4'hc, WAIT_NONE, WAIT_SHORT};
            4'd10:   s = '{4'h0, WAIT_NONE, WAIT_NONE};
            4'd11:   s = '{4'h1, WAIT_NONE, WAIT_LONG};
            4'd12:   s = '{4'h0, WAIT_NONE, WAIT_NONE};
            4'd13:   s = '{4'h6, WAIT_NONE, WAIT_SHORT};
            4'd14:   s = '{4'h0, WAIT_NONE, WAIT_NONE};
            default: s = '{4'h1, WAIT_NONE, WAIT_LONG};
        endcase
        return s;
    endfunction

endpackage

### design/lcdts_front.sv
`timescale 1ns / 1ps

module lcdts_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  lcdts_pkg::cmd_item_t cmd_item,
    input  logic                 queue_full,
    output logic                 push,
    output lcdts_pkg::run_t      push_run
);

    logic [6:0] cursor_reg;
    logic [6:0] cursor_next;
    logic [6:0] addr_dec;
    logic [6:0] addr_inc;
    logic [6:0] addr_set;
    logic       has_run;
    logic       accept;

    assign cmd_stall = queue_full;
    assign accept    = cmd_valid && !queue_full;
    assign push      = accept && has_run;

    assign addr_dec = cursor_reg - 7'd1;
    assign addr_inc = cursor_reg + 7'd1;
    // col - 1 modulo 128; a row above one toggles into line two
    assign addr_set = ({1'b0, cmd_item.col} - 7'd1)
                      ^ ((cmd_item.row > 2'd1) ? lcdts_pkg::ADDR_LINE2 : 7'd0);

    always_comb
    begin
        cursor_next = cursor_reg;
        has_run     = 1'b0;
        push_run    = '{kind: lcdts_pkg::RUN_BYTE, data: 8'h00,
                        reg_select: lcdts_pkg::RS_CMD, post_wait: lcdts_pkg::WAIT_SHORT};
        unique case (cmd_item.opcode)
            lcdts_pkg::OP_PUT_CHAR:
            begin
                if (cmd_item.char_code == lcdts_pkg::CH_BACKSPACE)
                begin
                    if (cursor_reg != 7'd0)
                    begin
                        cursor_next   = addr_dec;
                        has_run       = 1'b1;
                        push_run.kind = lcdts_pkg::RUN_BACKSPACE;
                        push_run.data = lcdts_pkg::CMD_SET_DDRAM | {1'b0, addr_dec};
                    end
                end
                else if (cmd_item.char_code == lcdts_pkg::CH_NEWLINE)
                begin
                    has_run = 1'b1;
                    if (cursor_reg < lcdts_pkg::ADDR_LINE2)
                    begin
                        cursor_next   = lcdts_pkg::ADDR_LINE2;
                        push_run.data = lcdts_pkg::CMD_SET_DDRAM
                                        | {1'b0, lcdts_pkg::ADDR_LINE2};
                    end
                    else
                    begin
                        cursor_next        = 7'd0;
                        push_run.data      = lcdts_pkg::CMD_CLEAR;
                        push_run.post_wait = lcdts_pkg::WAIT_LONG;
                    end
                end
                else
                begin
                    has_run             = 1'b1;
                    push_run.data       = cmd_item.char_code;
                    push_run.reg_select = lcdts_pkg::RS_DATA;
                    // wrap line one into line two, line two back to home
                    if (addr_inc == lcdts_pkg::ADDR_LINE1_END)
                        cursor_next = lcdts_pkg::ADDR_LINE2;
                    else if (addr_inc == lcdts_pkg::ADDR_LINE2_END)
                        cursor_next = 7'd0;
                    else
                        cursor_next = addr_inc;
                end
            end
            lcdts_pkg::OP_SET_POS:
            begin
                has_run       = 1'b1;
                cursor_next   = addr_set;
                push_run.data = lcdts_pkg::CMD_SET_DDRAM | {1'b0, addr_set};
            end
            lcdts_pkg::OP_CLEAR:
            begin
                has_run            = 1'b1;
                cursor_next        = 7'd0;
                push_run.data      = lcdts_pkg::CMD_CLEAR;
                push_run.post_wait = lcdts_pkg::WAIT_LONG;
            end
            lcdts_pkg::OP_CURSOR_ON:
            begin
                has_run       = 1'b1;
                push_run.data = lcdts_pkg::CMD_CURSOR_ON;
            end
            lcdts_pkg::OP_CURSOR_OFF:
            begin
                has_run       = 1'b1;
                push_run.data = lcdts_pkg::CMD_CURSOR_OFF;
            end
            lcdts_pkg::OP_INIT:
            begin
                has_run       = 1'b1;
                cursor_next   = 7'd0;
                push_run.kind = lcdts_pkg::RUN_INIT;
            end
            default:
            begin
                has_run = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cursor_reg <= 7'd0;
        else if (accept)
            cursor_reg <= cursor_next;
    end

endmodule

### design/lcdts_queue.sv
`timescale 1ns / 1ps

module lcdts_queue #(
    parameter int Depth = lcdts_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lcdts_pkg::run_t push_run,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output lcdts_pkg::run_t head_run
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    lcdts_pkg::run_t mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_run   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    assign wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_next;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### design/lcdts_back.sv
`timescale 1ns / 1ps

module lcdts_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  lcdts_pkg::run_t      head_run,
    output logic                 pop,
    output logic                 lcd_valid,
    input  logic                 lcd_stall,
    output lcdts_pkg::lcd_item_t lcd_item
);

    logic [3:0]           step_reg;
    logic [3:0]           step_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    lcdts_pkg::lcd_item_t out_reg;
    lcdts_pkg::lcd_item_t strobe;
    lcdts_pkg::init_step_t init_s;
    logic [7:0]           bs_byte;
    logic                 bs_rs;
    logic                 load;

    assign lcd_valid = out_valid_reg;
    assign lcd_item  = out_reg;

    assign init_s = lcdts_pkg::init_strobe(step_reg);

    // Backspace: set position, space, set position again
    assign bs_byte = (step_reg[2:1] == 2'd1) ? lcdts_pkg::CH_SPACE : head_run.data;
    assign bs_rs   = (step_reg[2:1] == 2'd1) ? lcdts_pkg::RS_DATA : lcdts_pkg::RS_CMD;

    always_comb
    begin
        strobe = '0;
        unique case (head_run.kind)
            lcdts_pkg::RUN_BYTE:
            begin
                strobe.nibble     = step_reg[0] ? head_run.data[3:0] : head_run.data[7:4];
                strobe.reg_select = head_run.reg_select;
                strobe.pre_wait   = lcdts_pkg::WAIT_NONE;
                strobe.post_wait  = step_reg[0] ? head_run.post_wait : lcdts_pkg::WAIT_NONE;
                strobe.last       = (step_reg == lcdts_pkg::LAST_STEP_BYTE);
            end
            lcdts_pkg::RUN_BACKSPACE:
            begin
                strobe.nibble     = step_reg[0] ? bs_byte[3:0] : bs_byte[7:4];
                strobe.reg_select = bs_rs;
                strobe.pre_wait   = lcdts_pkg::WAIT_NONE;
                strobe.post_wait  = step_reg[0] ? lcdts_pkg::WAIT_SHORT
                                                : lcdts_pkg::WAIT_NONE;
                strobe.last       = (step_reg == lcdts_pkg::LAST_STEP_BACKSPACE);
            end
            lcdts_pkg::RUN_INIT:
            begin
                strobe.nibble     = init_s.nibble;
                strobe.reg_select = lcdts_pkg::RS_CMD;
                strobe.pre_wait   = init_s.pre_wait;
                strobe.post_wait  = init_s.post_wait;
                strobe.last       = (step_reg == lcdts_pkg::LAST_STEP_INIT);
            end
            default:
            begin
                strobe = '0;
            end
        endcase
    end

    // Load a new strobe whenever the output register is free or draining
    assign load           = head_valid && (!out_valid_reg || !lcd_stall);
    assign pop            = load && strobe.last;
    assign out_valid_next = load || (out_valid_reg && lcd_stall);

    always_comb
    begin
        step_next = step_reg;
        if (load)
            step_next = strobe.last ? 4'd0 : step_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= strobe;
    end

endmodule

### design/char_lcd_terminal_sequencer.sv
`timescale 1ns / 1ps
// Path: an accepted operation enters the run queue, then its first strobe is registered at the output.
// Throughput: one strobe per cycle from the back end while lcd_stall is low; an operation is 2 strobes
// (single byte), 6 (backspace) or 16 (init), set by the strobe step counter.
// The run queue lets the front take new operations while strobes are still pending.
// Reset: asynchronous, active low; cursor address 0, queue empty, no strobe valid.

module char_lcd_terminal_sequencer #(
    parameter int QueueDepth = lcdts_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  lcdts_pkg::cmd_item_t cmd_item,
    output logic                 lcd_valid,
    input  logic                 lcd_stall,
    output lcdts_pkg::lcd_item_t lcd_item
);

    logic            push;
    lcdts_pkg::run_t push_run;
    logic            queue_full;
    logic            pop;
    logic            head_valid;
    lcdts_pkg::run_t head_run;

    lcdts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item),
        .queue_full (queue_full),
        .push       (push),
        .push_run   (push_run)
    );

    lcdts_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_run   (push_run),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_run   (head_run)
    );

    lcdts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_run   (head_run),
        .pop        (pop),
        .lcd_valid  (lcd_valid),
        .lcd_stall  (lcd_stall),
        .lcd_item   (lcd_item)
    );

endmodule
